// ----- src/hrtp_pkg.sv -----
// Shared types and constants for the request-target parser.
// Used by the front classifier, the queue, the parse engine and the top level.
package hrtp_pkg;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        absolute_form;
      logic        host_is_ipv4;
      logic [11:0] host_start;
      logic [12:0] host_length;
      logic        port_present;
      logic [15:0] port_value;
      logic [11:0] path_start;
      logic [12:0] path_length;
      logic        query_present;
      logic [11:0] query_start;
      logic [12:0] query_length;
   } rsp_type;

   // Character classes computed by the front part.
   typedef struct packed {
      logic       is_digit;
      logic       is_hex;
      logic       is_host;
      logic       is_pchar;
      logic       is_qchar;
      logic       is_pct;
      logic       is_slash;
      logic       is_quest;
      logic       is_colon;
      logic       is_dot;
      logic [3:0] digit;
   } cls_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       line_end;
      cls_type    cls;
   } tok_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_PREFIX,
      PH_HOST_FIRST,
      PH_HOSTNAME,
      PH_IPV4,
      PH_IPV4_DOT,
      PH_PORT_FIRST,
      PH_PORT,
      PH_PATH,
      PH_QUERY
   } phase_type;

   localparam int SCHEME_LEN = 7;
   localparam logic [7:0] SCHEME_TEXT [SCHEME_LEN] = '{
      8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F
   };
   localparam logic [7:0] OCTET_MAX = 8'd255;
   localparam logic [16:0] PORT_MAX = 17'd65535;
   localparam logic [2:0] PORT_DIGITS_MAX = 3'd5;

   function automatic cls_type classify(input logic [7:0] c);
      cls_type r;
      logic alpha;
      logic unres;
      logic sub;
      alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      r.is_digit = (c >= 8'h30 && c <= 8'h39);
      r.is_hex = r.is_digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
      unres = alpha || r.is_digit || c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E;
      sub = c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 || c == 8'h28 ||
            c == 8'h29 || c == 8'h2A || c == 8'h2B || c == 8'h2C || c == 8'h3B ||
            c == 8'h3D;
      r.is_host = unres || sub;
      r.is_pchar = r.is_host || c == 8'h3A || c == 8'h40;
      r.is_qchar = r.is_pchar || c == 8'h2F || c == 8'h3F;
      r.is_pct = (c == 8'h25);
      r.is_slash = (c == 8'h2F);
      r.is_quest = (c == 8'h3F);
      r.is_colon = (c == 8'h3A);
      r.is_dot = (c == 8'h2E);
      r.digit = c[3:0];
      return r;
   endfunction

endpackage

// ----- src/hrtp_front.sv -----
// Front part: takes request bytes and tags them with character classes.
// Depends on hrtp_pkg.
module hrtp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hrtp_pkg::req_type req_data,
   output logic             tok_valid,
   input  logic             tok_stall,
   output hrtp_pkg::tok_type tok_data
);
   import hrtp_pkg::*;

   logic    valid_ff, valid_in;
   tok_type data_ff, data_in;

   assign req_stall = valid_ff && tok_stall;
   assign tok_valid = valid_ff;
   assign tok_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         data_in.char_byte = req_data.char_byte;
         data_in.line_end  = req_data.line_end;
         data_in.cls       = classify(req_data.char_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      data_ff <= data_in;
   end
endmodule

// ----- src/hrtp_queue.sv -----
// Two-entry queue between the front classifier and the parse engine.
// Depends on hrtp_pkg.
module hrtp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  hrtp_pkg::tok_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output hrtp_pkg::tok_type out_data
);
   import hrtp_pkg::*;

   tok_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

// ----- src/hrtp_engine.sv -----
// Back part: per-byte parse state machine and verdict output register.
// Depends on hrtp_pkg.
module hrtp_engine #(
   parameter int MAX_LINE_LENGTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_valid,
   output logic              tok_stall,
   input  hrtp_pkg::tok_type tok_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrtp_pkg::rsp_type rsp_data
);
   import hrtp_pkg::*;

   localparam int PW = $clog2(MAX_LINE_LENGTH + 1);
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_LINE_LENGTH);

   phase_type   phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [2:0]  pfx_ff, pfx_in;
   logic [1:0]  esc_ff, esc_in;
   logic [1:0]  oidx_ff, oidx_in;
   logic [7:0]  oval_ff, oval_in;
   logic [1:0]  ocnt_ff, ocnt_in;
   logic [16:0] port_ff, port_in;
   logic [2:0]  psig_ff, psig_in;
   logic [PW-1:0] hs_ff, hs_in, he_ff, he_in, ps_ff, ps_in, pe_ff, pe_in;
   logic [PW-1:0] qs_ff, qs_in, qe_ff, qe_in;
   logic        fabs_ff, fabs_in, fip_ff, fip_in, fport_ff, fport_in;
   logic        fpath_ff, fpath_in, fq_ff, fq_in;
   logic        bad_ff, bad_in;
   logic        ovalid_ff, ovalid_in;
   rsp_type     odata_ff, odata_in;

   logic    take;
   cls_type k;
   logic [7:0] c;
   logic [PW-1:0] pos1;
   logic [10:0] oprod;
   logic [19:0] pprod;
   logic    ok;
   rsp_type v;

   assign tok_stall = ovalid_ff && rsp_stall;
   assign take      = tok_valid && !tok_stall;
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = odata_ff;
   assign k    = tok_data.cls;
   assign c    = tok_data.char_byte;
   assign pos1 = pos_ff + PW'(1);
   assign oprod = {oval_ff, 3'b0} + {2'b0, oval_ff, 1'b0} + {7'b0, k.digit};
   assign pprod = {port_ff, 3'b0} + {2'b0, port_ff, 1'b0} + {16'b0, k.digit};

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; pfx_in = pfx_ff; esc_in = esc_ff;
      oidx_in = oidx_ff; oval_in = oval_ff; ocnt_in = ocnt_ff;
      port_in = port_ff; psig_in = psig_ff;
      hs_in = hs_ff; he_in = he_ff; ps_in = ps_ff; pe_in = pe_ff;
      qs_in = qs_ff; qe_in = qe_ff;
      fabs_in = fabs_ff; fip_in = fip_ff; fport_in = fport_ff;
      fpath_in = fpath_ff; fq_in = fq_ff; bad_in = bad_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in = odata_ff;
      ok = 1'b0;
      v = '0;

      if (take) begin
         if (pos_ff >= POS_MAX) begin
            bad_in = 1'b1;
         end else begin
            pos_in = pos1;
            if (!bad_ff) begin
               if (esc_ff != 2'd0) begin
                  if (!k.is_hex) bad_in = 1'b1;
                  else begin
                     esc_in = esc_ff - 2'd1;
                     if (phase_ff == PH_HOSTNAME) he_in = pos1;
                     else if (phase_ff == PH_PATH) pe_in = pos1;
                     else qe_in = pos1;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_START: begin
                        if (k.is_slash) begin
                           phase_in = PH_PATH; fpath_in = 1'b1; ps_in = pos_ff; pe_in = pos1;
                        end else if (c == SCHEME_TEXT[0]) begin
                           phase_in = PH_PREFIX; pfx_in = 3'd1;
                        end else bad_in = 1'b1;
                     end
                     PH_PREFIX: begin
                        if (c != SCHEME_TEXT[pfx_ff]) bad_in = 1'b1;
                        else begin
                           pfx_in = pfx_ff + 3'd1;
                           if (pfx_ff == 3'(SCHEME_LEN - 1)) begin
                              phase_in = PH_HOST_FIRST; fabs_in = 1'b1;
                           end
                        end
                     end
                     PH_HOST_FIRST: begin
                        hs_in = pos_ff; he_in = pos1;
                        if (k.is_digit) begin
                           phase_in = PH_IPV4; fip_in = 1'b1; oidx_in = 2'd0;
                           oval_in = {4'b0, k.digit}; ocnt_in = 2'd1;
                        end else if (k.is_host) phase_in = PH_HOSTNAME;
                        else if (k.is_pct) begin
                           phase_in = PH_HOSTNAME; esc_in = 2'd2;
                        end else bad_in = 1'b1;
                     end
                     PH_HOSTNAME, PH_IPV4, PH_PORT_FIRST, PH_PORT: begin
                        if (phase_ff == PH_HOSTNAME && k.is_host) he_in = pos1;
                        else if (phase_ff == PH_HOSTNAME && k.is_pct) begin
                           esc_in = 2'd2; he_in = pos1;
                        end else if (phase_ff == PH_IPV4 && k.is_digit) begin
                           he_in = pos1;
                           if (oval_ff == 8'd0 || ocnt_ff == 2'd3) bad_in = 1'b1;
                           else begin
                              oval_in = oprod[7:0]; ocnt_in = ocnt_ff + 2'd1;
                              if (oprod > {3'b0, OCTET_MAX}) bad_in = 1'b1;
                           end
                        end else if (phase_ff == PH_IPV4 && oidx_ff != 2'd3) begin
                           if (k.is_dot) begin
                              phase_in = PH_IPV4_DOT; he_in = pos1;
                           end else bad_in = 1'b1;
                        end else if ((phase_ff == PH_PORT_FIRST || phase_ff == PH_PORT)
                                     && k.is_digit) begin
                           phase_in = PH_PORT;
                           if (k.digit != 4'd0 || psig_ff != 3'd0) begin
                              psig_in = psig_ff + 3'd1;
                              if (psig_ff == PORT_DIGITS_MAX) bad_in = 1'b1;
                              else begin
                                 port_in = pprod[16:0];
                                 if (pprod > {3'b0, PORT_MAX}) bad_in = 1'b1;
                              end
                           end
                        end else if (phase_ff == PH_PORT_FIRST) bad_in = 1'b1;
                        else if (phase_ff != PH_PORT && k.is_colon) begin
                           phase_in = PH_PORT_FIRST; fport_in = 1'b1;
                        end else if (k.is_slash) begin
                           phase_in = PH_PATH; fpath_in = 1'b1; ps_in = pos_ff; pe_in = pos1;
                        end else if (k.is_quest) begin
                           phase_in = PH_QUERY; fq_in = 1'b1; qs_in = pos1; qe_in = pos1;
                        end else bad_in = 1'b1;
                     end
                     PH_IPV4_DOT: begin
                        if (!k.is_digit) bad_in = 1'b1;
                        else begin
                           phase_in = PH_IPV4; oidx_in = oidx_ff + 2'd1;
                           oval_in = {4'b0, k.digit}; ocnt_in = 2'd1; he_in = pos1;
                        end
                     end
                     PH_PATH: begin
                        if (k.is_pchar || k.is_slash) pe_in = pos1;
                        else if (k.is_pct) begin
                           esc_in = 2'd2; pe_in = pos1;
                        end else if (k.is_quest) begin
                           phase_in = PH_QUERY; fq_in = 1'b1; qs_in = pos1; qe_in = pos1;
                        end else bad_in = 1'b1;
                     end
                     PH_QUERY: begin
                        if (k.is_qchar) qe_in = pos1;
                        else if (k.is_pct) begin
                           esc_in = 2'd2; qe_in = pos1;
                        end else bad_in = 1'b1;
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
            end
         end

         if (tok_data.line_end) begin
            // judge on the state after this byte
            if (!bad_in && esc_in == 2'd0) begin
               case (phase_in)
                  PH_HOSTNAME, PH_PORT, PH_PATH, PH_QUERY: ok = 1'b1;
                  PH_IPV4: ok = (oidx_in == 2'd3) && (ocnt_in != 2'd0);
                  default: ok = 1'b0;
               endcase
            end
            if (ok) begin
               v.accepted = 1'b1;
               if (fabs_in) begin
                  v.absolute_form = 1'b1;
                  v.host_is_ipv4  = fip_in;
                  v.host_start    = 12'(hs_in);
                  v.host_length   = 13'(he_in - hs_in);
               end
               if (fport_in) begin
                  v.port_present = 1'b1;
                  v.port_value   = port_in[15:0];
               end
               if (fpath_in) begin
                  v.path_start  = 12'(ps_in);
                  v.path_length = 13'(pe_in - ps_in);
               end
               if (fq_in) begin
                  v.query_present = 1'b1;
                  v.query_start   = 12'(qs_in);
                  v.query_length  = 13'(qe_in - qs_in);
               end
            end
            ovalid_in = 1'b1;
            odata_in  = v;
            phase_in = PH_START; pos_in = '0; pfx_in = '0; esc_in = '0;
            oidx_in = '0; oval_in = '0; ocnt_in = '0; port_in = '0; psig_in = '0;
            hs_in = '0; he_in = '0; ps_in = '0; pe_in = '0; qs_in = '0; qe_in = '0;
            fabs_in = 1'b0; fip_in = 1'b0; fport_in = 1'b0; fpath_in = 1'b0;
            fq_in = 1'b0; bad_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START; pos_ff <= '0; pfx_ff <= '0; esc_ff <= '0;
         oidx_ff <= '0; oval_ff <= '0; ocnt_ff <= '0; port_ff <= '0; psig_ff <= '0;
         hs_ff <= '0; he_ff <= '0; ps_ff <= '0; pe_ff <= '0; qs_ff <= '0; qe_ff <= '0;
         fabs_ff <= 1'b0; fip_ff <= 1'b0; fport_ff <= 1'b0; fpath_ff <= 1'b0;
         fq_ff <= 1'b0; bad_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; pfx_ff <= pfx_in; esc_ff <= esc_in;
         oidx_ff <= oidx_in; oval_ff <= oval_in; ocnt_ff <= ocnt_in;
         port_ff <= port_in; psig_ff <= psig_in;
         hs_ff <= hs_in; he_ff <= he_in; ps_ff <= ps_in; pe_ff <= pe_in;
         qs_ff <= qs_in; qe_ff <= qe_in;
         fabs_ff <= fabs_in; fip_ff <= fip_in; fport_ff <= fport_in;
         fpath_ff <= fpath_in; fq_ff <= fq_in; bad_ff <= bad_in;
         ovalid_ff <= ovalid_in;
      end
      odata_ff <= odata_in;
   end
endmodule

// ----- src/http_request_target_parser.sv -----
// Request-target parser: one byte per cycle, back-to-back across lines.
// A verdict is registered: the last byte of a line passes the classify register,
// then a queue entry, and then the verdict register is loaded.
// Throughput: one byte per cycle; a verdict held by rsp_stall stalls the engine,
// and the two-entry queue plus the classify register then back up into req_stall.
// Reset is synchronous, active high; it empties the queue and restarts a line.
// Depends on hrtp_pkg, hrtp_front, hrtp_queue and hrtp_engine.
module http_request_target_parser #(
   parameter int MAX_LINE_LENGTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrtp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrtp_pkg::rsp_type rsp_data
);
   import hrtp_pkg::*;

   logic    f_valid, f_stall, q_valid, q_stall;
   tok_type f_data, q_data;

   hrtp_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .tok_valid(f_valid), .tok_stall(f_stall), .tok_data(f_data)
   );

   hrtp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   hrtp_engine #(.MAX_LINE_LENGTH(MAX_LINE_LENGTH)) u_engine (
      .clock(clock), .reset(reset),
      .tok_valid(q_valid), .tok_stall(q_stall), .tok_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule
